// File: sv/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/tekd_pkg.sv
// Package for the terminal escape key decoder: payload types, byte and
// key codes, and the final-byte lookup functions. No dependencies.
package tekd_pkg;

    // Default saturation value of a numeric parameter
    localparam int unsigned PARAM_MAX_DEF = 255;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_PARAMS = 2'd2
    } t_mode;

    // Result kinds
    localparam logic [2:0] KIND_PLAIN   = 3'd0;
    localparam logic [2:0] KIND_ALT     = 3'd1;
    localparam logic [2:0] KIND_KEY     = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    // Bytes of interest
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
    localparam logic [7:0] CH_SS3   = 8'h4F;  // 'O'
    localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;

    // Key numbers
    localparam logic [7:0] KEY_UP    = 8'd0;
    localparam logic [7:0] KEY_DN    = 8'd1;
    localparam logic [7:0] KEY_RT    = 8'd2;
    localparam logic [7:0] KEY_LT    = 8'd3;
    localparam logic [7:0] KEY_HM    = 8'd4;
    localparam logic [7:0] KEY_END   = 8'd5;
    localparam logic [7:0] KEY_INS   = 8'd6;
    localparam logic [7:0] KEY_DEL   = 8'd7;
    localparam logic [7:0] KEY_PG_UP = 8'd8;
    localparam logic [7:0] KEY_PGDN  = 8'd9;
    localparam logic [7:0] KEY_F1    = 8'd10;
    localparam logic [7:0] KEY_F2    = 8'd11;
    localparam logic [7:0] KEY_F3    = 8'd12;
    localparam logic [7:0] KEY_F4    = 8'd13;
    localparam logic [7:0] KEY_F5    = 8'd14;
    localparam logic [7:0] KEY_F6    = 8'd15;
    localparam logic [7:0] KEY_F7    = 8'd16;
    localparam logic [7:0] KEY_F8    = 8'd17;
    localparam logic [7:0] KEY_F9    = 8'd18;
    localparam logic [7:0] KEY_F10   = 8'd19;
    localparam logic [7:0] KEY_F11   = 8'd20;
    localparam logic [7:0] KEY_F12   = 8'd21;

    // Widest numeric parameter handled by the lookups
    localparam int unsigned PNUM_W = 16;

    // Parameter count saturates here ("more than two")
    localparam logic [1:0] PCOUNT_MAX = 2'd3;
    localparam logic [1:0] PCOUNT_TWO = 2'd2;

    // Decimal radix for the accumulator
    localparam int unsigned RADIX = 10;

    // Modifier range
    localparam int unsigned MOD_MIN = 1;
    localparam int unsigned MOD_MAX = 8;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] code;
        logic [3:0] modifier;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] key;
    } t_key_hit;

    // '~' sequences: first parameter to key number
    function automatic t_key_hit tilde_key(input logic [PNUM_W-1:0] p);
        t_key_hit r;
        r.hit = 1'b1;
        r.key = KEY_UP;
        case (p)
            16'd2:   r.key = KEY_INS;
            16'd3:   r.key = KEY_DEL;
            16'd5:   r.key = KEY_PG_UP;
            16'd6:   r.key = KEY_PGDN;
            16'd15:  r.key = KEY_F5;
            16'd17:  r.key = KEY_F6;
            16'd18:  r.key = KEY_F7;
            16'd19:  r.key = KEY_F8;
            16'd20:  r.key = KEY_F9;
            16'd21:  r.key = KEY_F10;
            16'd23:  r.key = KEY_F11;
            16'd24:  r.key = KEY_F12;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Letter finals: byte to key number
    function automatic t_key_hit letter_key(input logic [7:0] b);
        t_key_hit r;
        r.hit = 1'b1;
        r.key = KEY_UP;
        case (b)
            8'h41:   r.key = KEY_UP;     // 'A'
            8'h42:   r.key = KEY_DN;     // 'B'
            8'h43:   r.key = KEY_RT;     // 'C'
            8'h44:   r.key = KEY_LT;     // 'D'
            8'h48:   r.key = KEY_HM;     // 'H'
            8'h46:   r.key = KEY_END;    // 'F'
            8'h50:   r.key = KEY_F1;     // 'P'
            8'h51:   r.key = KEY_F2;     // 'Q'
            8'h52:   r.key = KEY_F3;     // 'R'
            8'h53:   r.key = KEY_F4;     // 'S'
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/terminal_escape_key_decoder.sv
// Terminal escape key decoder: keyboard bytes and escape-window expiry in,
// decoded key transactions out. Depends on tekd_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// One transaction per cycle while o_in_ready is high: state and result are
// computed in the cycle of acceptance and the result is registered.
// A two-entry result store (output register plus skid register) keeps
// o_in_ready high while a single result waits; ready drops only when both hold.
// Synchronous active-low reset returns to idle with cleared parameters.
module terminal_escape_key_decoder #(
    parameter int unsigned PARAM_MAX = tekd_pkg::PARAM_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tekd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tekd_pkg::t_out_item o_out_data
);

    localparam int unsigned ACC_W = $clog2(PARAM_MAX + 1);
    localparam int unsigned PRD_W = ACC_W + 4;

    // Decoder state
    tekd_pkg::t_mode  r_mode,  n_mode;
    logic [ACC_W-1:0] r_accum, n_accum;
    logic [ACC_W-1:0] r_first, n_first;
    logic [ACC_W-1:0] r_last,  n_last;
    logic [1:0]       r_count, n_count;

    // Output stage
    logic                r_out_valid, r_skid_valid;
    tekd_pkg::t_out_item r_out, r_skid;

    logic                in_fire, out_take;
    logic                is_digit, is_semi;
    logic [PRD_W-1:0]    acc_prod;
    logic [ACC_W-1:0]    acc_sat;
    logic [1:0]          cnt_inc;

    logic                res_valid;
    tekd_pkg::t_out_item res;
    tekd_pkg::t_out_item fin_res;

    logic [ACC_W-1:0]    fin_first, fin_last;
    logic [1:0]          fin_count;
    logic                last_ok;
    tekd_pkg::t_key_hit  tk, lk;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Byte classes
    always_comb begin
        is_digit = i_in_data.byte_in inside {[tekd_pkg::CH_0:tekd_pkg::CH_9]};
        is_semi  = i_in_data.byte_in == tekd_pkg::CH_SEMI;
    end

    // Decimal accumulate with saturation
    always_comb begin
        acc_prod = PRD_W'(r_accum) * PRD_W'(tekd_pkg::RADIX)
                 + PRD_W'(i_in_data.byte_in - tekd_pkg::CH_0);
        acc_sat  = (acc_prod > PRD_W'(PARAM_MAX)) ? ACC_W'(PARAM_MAX) : acc_prod[ACC_W-1:0];
        cnt_inc  = (r_count == tekd_pkg::PCOUNT_MAX) ? r_count : r_count + 2'd1;
    end

    // Parameters as they stand once the final byte has stored a nonzero number
    always_comb begin
        fin_first = r_first;
        fin_last  = r_last;
        fin_count = r_count;
        if (r_accum != '0) begin
            if (r_count == 2'd0) begin
                fin_first = r_accum;
            end
            fin_last  = r_accum;
            fin_count = cnt_inc;
        end
        last_ok = (fin_last >= ACC_W'(tekd_pkg::MOD_MIN))
               && (fin_last <= ACC_W'(tekd_pkg::MOD_MAX));
        tk = tekd_pkg::tilde_key(tekd_pkg::PNUM_W'(fin_first));
        lk = tekd_pkg::letter_key(i_in_data.byte_in);
    end

    // Final byte decode
    always_comb begin
        fin_res.kind     = tekd_pkg::KIND_UNKNOWN;
        fin_res.code     = i_in_data.byte_in;
        fin_res.modifier = 4'd0;
        if (i_in_data.byte_in == tekd_pkg::CH_TILDE) begin
            if (fin_count != 2'd0 && fin_count != tekd_pkg::PCOUNT_MAX && tk.hit) begin
                fin_res.kind = tekd_pkg::KIND_KEY;
                fin_res.code = tk.key;
                if (fin_count == tekd_pkg::PCOUNT_TWO && last_ok) begin
                    fin_res.modifier = fin_last[3:0];
                end
            end
        end else if (lk.hit) begin
            if (fin_count == 2'd0) begin
                fin_res.kind = tekd_pkg::KIND_KEY;
                fin_res.code = lk.key;
            end else if (last_ok) begin
                fin_res.kind     = tekd_pkg::KIND_KEY;
                fin_res.code     = lk.key;
                fin_res.modifier = fin_last[3:0];
            end
        end
    end

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_first = r_first;
        n_last  = r_last;
        n_count = r_count;
        if (in_fire) begin
            case (r_mode)
                tekd_pkg::MODE_ESC: begin
                    n_mode = tekd_pkg::MODE_IDLE;
                    if (!i_in_data.func && (i_in_data.byte_in == tekd_pkg::CH_LBRK
                                         || i_in_data.byte_in == tekd_pkg::CH_SS3)) begin
                        n_mode  = tekd_pkg::MODE_PARAMS;
                        n_accum = '0;
                        n_first = '0;
                        n_last  = '0;
                        n_count = 2'd0;
                    end
                end
                tekd_pkg::MODE_PARAMS: begin
                    if (!i_in_data.func && is_digit) begin
                        n_accum = acc_sat;
                    end else if (!i_in_data.func && is_semi) begin
                        if (r_count == 2'd0) begin
                            n_first = r_accum;
                        end
                        n_last  = r_accum;
                        n_count = cnt_inc;
                        n_accum = '0;
                    end else begin
                        // timeout or final byte: sequence ends
                        n_mode  = tekd_pkg::MODE_IDLE;
                        n_accum = '0;
                        n_first = '0;
                        n_last  = '0;
                        n_count = 2'd0;
                    end
                end
                default: begin
                    n_mode = tekd_pkg::MODE_IDLE;
                    if (!i_in_data.func && i_in_data.byte_in == tekd_pkg::CH_ESC) begin
                        n_mode = tekd_pkg::MODE_ESC;
                    end
                end
            endcase
        end
    end

    // Result of the accepted transaction
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (in_fire) begin
            case (r_mode)
                tekd_pkg::MODE_ESC: begin
                    if (i_in_data.func) begin
                        res_valid = 1'b1;
                        res.kind  = tekd_pkg::KIND_PLAIN;
                        res.code  = tekd_pkg::CH_ESC;
                    end else if (i_in_data.byte_in != tekd_pkg::CH_LBRK
                              && i_in_data.byte_in != tekd_pkg::CH_SS3) begin
                        res_valid = 1'b1;
                        res.kind  = tekd_pkg::KIND_ALT;
                        res.code  = i_in_data.byte_in;
                    end
                end
                tekd_pkg::MODE_PARAMS: begin
                    if (i_in_data.func) begin
                        res_valid = 1'b1;
                        res.kind  = tekd_pkg::KIND_TIMEOUT;
                    end else if (!is_digit && !is_semi) begin
                        res_valid = 1'b1;
                        res       = fin_res;
                    end
                end
                default: begin
                    if (!i_in_data.func && i_in_data.byte_in != tekd_pkg::CH_ESC) begin
                        res_valid = 1'b1;
                        res.kind  = tekd_pkg::KIND_PLAIN;
                        res.code  = i_in_data.byte_in;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tekd_pkg::MODE_IDLE;
            r_accum <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_count <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

    // Output register and skid: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

endmodule

// File: sv/tekd_checker.sv
// Port-level checker for the terminal escape key decoder, bound to the top.
// Depends on tekd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tekd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tekd_pkg::t_out_item i_out_data
);

    // A stalled result holds
    `ASSERT_IMPLIES_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data))

    // Input back-pressure only with a result already waiting
    `ASSERT_IMPLIES(a_ready_low_needs_out, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // Only named keys carry a modifier
    `ASSERT_IMPLIES(a_mod_only_key, i_clk, i_rst_n, i_out_valid && i_out_data.modifier != 4'd0,
        i_out_data.kind == tekd_pkg::KIND_KEY && i_out_data.modifier <= 4'd8)

    // Timeouts carry no code
    `ASSERT_IMPLIES(a_timeout_empty, i_clk, i_rst_n,
        i_out_valid && i_out_data.kind == tekd_pkg::KIND_TIMEOUT,
        i_out_data.code == 8'd0 && i_out_data.modifier == 4'd0)

    // Kind stays within its codes, named keys within the key table
    `ASSERT_IMPLIES(a_kind_range, i_clk, i_rst_n, i_out_valid,
        i_out_data.kind <= tekd_pkg::KIND_TIMEOUT
        && (i_out_data.kind != tekd_pkg::KIND_KEY || i_out_data.code <= tekd_pkg::KEY_F12))

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
